[rtl/core/sorted_set_table_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted set table
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define SST_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that, once seen, is followed by a consequence in the next cycle.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sst_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted set table package
// Types, codes and constants shared by the sorted set table modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int ACTION_W     = 2;
    localparam int COUNT_W      = 5;

    // Action codes; the unused code behaves as a query.
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INS,
        SH_DEL
    } t_shift;

    typedef struct packed {
        t_shift                    op;
        logic signed [VALUE_W-1:0] key;
    } t_cell_cmd;

endpackage

[rtl/core/sst_if.sv]
// ----------------------------------------------------------------------------
// Sorted set table channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface sst_req_if
    import sst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sst_rsp_if
    import sst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               was_present;
    logic [COUNT_W-1:0] element_count;
    logic               full_reject;

    modport source (output valid, output was_present, output element_count,
                     output full_reject, input ready);
    modport sink   (input valid, input was_present, input element_count,
                    input full_reject, output ready);
endinterface

[rtl/core/sorted_set_table.sv]
// ----------------------------------------------------------------------------
// Sorted set table
// Holds up to CAPACITY distinct signed values in ascending order and answers
// query, add and remove requests with presence, count and full-reject flags.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req (action, value); each gives one response on
// o_rsp (was_present, element_count, full_reject). A request is taken in the
// idle state; every cell compares its entry with the value at that edge. In
// the update state the presence and full flags are reduced over the cells, the
// whole row shifts by one slot at once if the set changes, and the response
// is loaded into the output register. The block takes no new request until
// the update step of the previous one is done. The response register lets a
// new request be taken while an earlier response waits. If the receiver
// stalls with a response still held, the update step waits until that
// register frees.
// Reset empties the set at once: the fill mask and the count clear, and the
// slot contents are left as they are, since no slot beyond the count is read.
// ----------------------------------------------------------------------------
`include "sorted_set_table_defines.svh"

module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sst_req_if.sink    i_req,
    sst_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                    r_state;
    t_state                    n_state;
    logic signed [VALUE_W-1:0] r_key;
    logic [ACTION_W-1:0]       r_action;
    logic [CAPACITY-1:0]       r_fill;
    logic [CAPACITY-1:0]       n_fill;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic                      r_out_present;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_reject;

    logic                      req_fire;
    logic                      commit;
    logic                      present;
    logic                      full;
    logic                      reject;
    t_cell_cmd                 cmd;

    logic signed [VALUE_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       eq;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign commit      = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    // Distinct sorted entries: at most one cell can match.
    assign present = |eq;
    assign full    = r_fill[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                      prev_lt;
            logic signed [VALUE_W-1:0] prev_entry;
            logic signed [VALUE_W-1:0] next_entry;

            if (gi == 0) begin : g_first
                assign prev_lt    = 1'b1;
                assign prev_entry = '0;
            end else begin : g_inner
                assign prev_lt    = lt[gi-1];
                assign prev_entry = entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign next_entry = '0;
            end else begin : g_lower
                assign next_entry = entry[gi+1];
            end

            sst_cell u_cell (
                .i_clk        (i_clk),
                .i_cap        (req_fire),
                .i_value      (i_req.value),
                .i_valid      (r_fill[gi]),
                .i_cmd        (cmd),
                .i_prev_lt    (prev_lt),
                .i_prev_entry (prev_entry),
                .i_next_entry (next_entry),
                .o_entry      (entry[gi]),
                .o_lt         (lt[gi]),
                .o_eq         (eq[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_key    <= i_req.value;
            r_action <= i_req.action;
        end
        if (commit) begin
            r_out_present <= present;
            r_out_count   <= COUNT_W'(n_count);
            r_out_reject  <= reject;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_count = r_count;
        reject  = 1'b0;
        cmd.op  = SH_HOLD;
        cmd.key = r_key;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_action == ACT_ADD && !present) begin
                    reject = full;
                end
                if (commit) begin
                    n_state = S_IDLE;
                    if (r_action == ACT_ADD && !present && !full) begin
                        cmd.op  = SH_INS;
                        n_fill  = {r_fill[CAPACITY-2:0], 1'b1};
                        n_count = r_count + CNT_W'(1);
                    end else if (r_action == ACT_REMOVE && present) begin
                        cmd.op  = SH_DEL;
                        n_fill  = {1'b0, r_fill[CAPACITY-1:1]};
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.was_present   = r_out_present;
    assign o_rsp.element_count = r_out_count;
    assign o_rsp.full_reject   = r_out_reject;

    // The fill mask is a run of ones from the bottom slot, one per element.
    `SST_ASSERT_ALWAYS(a_fill_count, $countones(r_fill) == r_count,
        "fill mask disagrees with element count")
    `SST_ASSERT_ALWAYS(a_fill_thermo, ((r_fill + CAPACITY'(1)) & r_fill) == '0,
        "fill mask is not contiguous from the bottom slot")
    // Match flags are only meaningful once a request has been captured.
    `SST_ASSERT_ALWAYS(a_one_match, r_state != S_UPD || $onehot0(eq),
        "more than one slot matches the request value")
    `SST_ASSERT_NEXT(a_commit_rsp, commit, r_out_valid && r_state == S_IDLE,
        "update step did not load a response")
    `SST_ASSERT_NEXT(a_reject_keeps, commit && reject,
        $stable(r_fill) && r_out_reject && !r_out_present,
        "rejected add changed the set or reported presence")

endmodule

[rtl/core/sst_cell.sv]
// ----------------------------------------------------------------------------
// Sorted set table cell
// One table slot: compares its entry with a request value and shifts with
// its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module sst_cell
    import sst_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_cap,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_valid,
    input  t_cell_cmd                 i_cmd,
    input  logic                      i_prev_lt,
    input  logic signed [VALUE_W-1:0] i_prev_entry,
    input  logic signed [VALUE_W-1:0] i_next_entry,
    output logic signed [VALUE_W-1:0] o_entry,
    output logic                      o_lt,
    output logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;
    logic                      r_lt;
    logic                      r_eq;

    // Flags are taken when the request is accepted and hold until the update.
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_lt <= i_valid && (r_entry < i_value);
            r_eq <= i_valid && (r_entry == i_value);
        end
        r_entry <= n_entry;
    end

    // On insert, cells at or after the insert point move up by one, and the
    // cell at the insert point takes the new value. On delete, cells at or
    // after the removed entry take their upper neighbor.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            SH_INS: begin
                if (!r_lt) begin
                    n_entry = i_prev_lt ? i_cmd.key : i_prev_entry;
                end
            end
            SH_DEL: begin
                if (!r_lt) begin
                    n_entry = i_next_entry;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule
